FILE: design/ltwps_pkg.sv
// ----------------------------------------------------------------------------
// ltwps_pkg
// Shared widths, datapath operation codes and the controller/datapath
// interface types of the least-time weighted peer selector.
// ----------------------------------------------------------------------------
package ltwps_pkg;

  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = 4;            // peer index bits
  localparam int CNT_W     = 5;            // peer count bits (holds MAX_PEERS)
  localparam int TIME_BITS = 24;
  localparam int AVG_W     = 32;           // Q24.8 average
  localparam int SUM_W     = AVG_W + 4;    // sum of up to 16 averages
  localparam int NUM_W     = 40;           // report numerator
  localparam int MN_W      = AVG_W + CNT_W;
  localparam int W_W       = 57;           // weight, up to 2^56
  localparam int RANGE_W   = 61;           // sum of up to 16 weights
  localparam int RND_W     = 31;
  localparam int DIV_NW    = 49;           // divider dividend bits
  localparam int DIV_DW    = 44;           // divider divisor bits
  localparam int DIV_CW    = 6;

  // The report numerator is below 2^39, so multiplying by ceil(2^46 / 100)
  // and dropping 46 bits gives the exact quotient. The product is built from
  // four half-width partial products.
  localparam int RQ_H      = NUM_W / 2;
  localparam int PROD_W    = 4 * RQ_H;
  localparam int RQ_SHIFT  = 46;
  localparam logic [NUM_W-1:0] RECIP_100 = NUM_W'(64'd703687441777);

  localparam logic [DIV_NW-1:0] WEIGHT_ONE        = DIV_NW'(1) << 48;
  localparam logic [W_W-1:0]    UNMEASURED_WEIGHT = W_W'(1) << 56;
  localparam logic [AVG_W-1:0]  ONE_MS            = AVG_W'(256);
  localparam logic [6:0]        PERCENT           = 7'd100;
  localparam logic [6:0]        F_MAX             = 7'd99;

  // Configuration register indexes.
  localparam logic CFG_SMOOTHING = 1'b0;
  localparam logic CFG_NUM_PEERS = 1'b1;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_RPT_FAST  = 5'd2;
  localparam op_t OP_RMUL      = 5'd3;
  localparam op_t OP_RQ_STEP   = 5'd4;
  localparam op_t OP_RWB       = 5'd5;
  localparam op_t OP_SUM_STEP  = 5'd6;
  localparam op_t OP_DIV_MEAN  = 5'd7;
  localparam op_t OP_MSET      = 5'd8;
  localparam op_t OP_MN1       = 5'd9;
  localparam op_t OP_MN2       = 5'd10;
  localparam op_t OP_DIV_MIN   = 5'd11;
  localparam op_t OP_MIN_SET   = 5'd12;
  localparam op_t OP_DIV_UNM   = 5'd13;
  localparam op_t OP_UNM_SET   = 5'd14;
  localparam op_t OP_W_STEP    = 5'd15;
  localparam op_t OP_WMUL      = 5'd16;
  localparam op_t OP_DIV_W     = 5'd17;
  localparam op_t OP_WADD      = 5'd18;
  localparam op_t OP_PM_LO     = 5'd19;
  localparam op_t OP_PM_HI     = 5'd20;
  localparam op_t OP_PADD      = 5'd21;
  localparam op_t OP_PICK_STEP = 5'd22;
  localparam op_t OP_OUT       = 5'd23;

  typedef struct packed {
    op_t  op;
    logic div_go;
  } cmd_t;

  typedef struct packed {
    logic is_rpt;
    logic smp_valid;
    logic avg_zero;
    logic idx_last;
    logic ready_bit;
    logic cnt_zero;
    logic use_zero;
    logic div_done;
    logic range_zero;
    logic pick_hit;
    logic out_free;
    logic rq_last;
  } stat_t;

endpackage

FILE: design/least_time_weighted_peer_select.sv
// ----------------------------------------------------------------------------
// least_time_weighted_peer_select
// Weighted random least-time peer selector with moving-average reporting.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives exactly one result. A report
// that folds a sample into a measured average divides by 100 through a
// reciprocal product built from four partial products. A select uses the
// shared restoring divider once for the mean (when any ready peer is
// measured), once each for the minimum and unmeasured weights (the latter
// only when a mean is in use), and once per measured ready peer. A new
// request is taken as soon as the previous result sits in the output
// register.
module least_time_weighted_peer_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_ready_mask,
  input  logic [30:0] in_random_value,
  input  logic [3:0]  in_peer_index,
  input  logic [23:0] in_time_ms,
  input  logic        in_valid_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_chosen_peer,
  output logic        out_found,
  output logic [31:0] out_updated_average,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata
);
  import ltwps_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ltwps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ltwps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_req_type         (in_req_type),
    .in_ready_mask       (in_ready_mask),
    .in_random_value     (in_random_value),
    .in_peer_index       (in_peer_index),
    .in_time_ms          (in_time_ms),
    .in_valid_sample     (in_valid_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_chosen_peer     (out_chosen_peer),
    .out_found           (out_found),
    .out_updated_average (out_updated_average),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata)
  );

endmodule

FILE: design/ltwps_div.sv
// ----------------------------------------------------------------------------
// ltwps_div
// Restoring binary divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltwps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ltwps_pkg::DIV_NW-1:0]  num,
  input  logic [ltwps_pkg::DIV_DW-1:0]  den,
  output logic                          busy,
  output logic                          done,
  output logic [ltwps_pkg::DIV_NW-1:0]  quo
);
  import ltwps_pkg::*;

  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      quo_nxt = {quo_r[DIV_NW-2:0], ge};
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider finished without running");
`endif

endmodule

FILE: design/ltwps_ctrl.sv
// ----------------------------------------------------------------------------
// ltwps_ctrl
// Sequencer: steps each request through its datapath operations.
// ----------------------------------------------------------------------------
module ltwps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ltwps_pkg::stat_t  st,
  output ltwps_pkg::cmd_t   cmd
);
  import ltwps_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_RDIV    = 5'd2;
  localparam logic [4:0] S_RWB     = 5'd4;
  localparam logic [4:0] S_SUM     = 5'd5;
  localparam logic [4:0] S_MDIV    = 5'd6;
  localparam logic [4:0] S_MWAIT   = 5'd7;
  localparam logic [4:0] S_MSET    = 5'd8;
  localparam logic [4:0] S_MN1     = 5'd9;
  localparam logic [4:0] S_MN2     = 5'd10;
  localparam logic [4:0] S_MINDIV  = 5'd11;
  localparam logic [4:0] S_MINWAIT = 5'd12;
  localparam logic [4:0] S_MINSET  = 5'd13;
  localparam logic [4:0] S_UNMDIV  = 5'd14;
  localparam logic [4:0] S_UNMWAIT = 5'd15;
  localparam logic [4:0] S_UNMSET  = 5'd16;
  localparam logic [4:0] S_WSEL    = 5'd17;
  localparam logic [4:0] S_WDIV    = 5'd18;
  localparam logic [4:0] S_WWAIT   = 5'd19;
  localparam logic [4:0] S_WADD    = 5'd20;
  localparam logic [4:0] S_RNG     = 5'd21;
  localparam logic [4:0] S_PMH     = 5'd22;
  localparam logic [4:0] S_PADD    = 5'd23;
  localparam logic [4:0] S_PICK    = 5'd24;
  localparam logic [4:0] S_OUT     = 5'd25;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    cmd.div_go = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (st.is_rpt) begin
          if (!st.smp_valid || st.avg_zero) begin
            cmd.op    = OP_RPT_FAST;
            state_nxt = S_OUT;
          end else begin
            cmd.op    = OP_RMUL;
            state_nxt = S_RDIV;
          end
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_RDIV: begin
        cmd.op = OP_RQ_STEP;
        if (st.rq_last) state_nxt = S_RWB;
      end
      S_RWB: begin
        cmd.op    = OP_RWB;
        state_nxt = S_OUT;
      end
      S_SUM: begin
        cmd.op = OP_SUM_STEP;
        if (st.idx_last) state_nxt = S_MDIV;
      end
      S_MDIV: begin
        if (st.cnt_zero) begin
          state_nxt = S_MN1;
        end else begin
          cmd.op     = OP_DIV_MEAN;
          cmd.div_go = 1'b1;
          state_nxt  = S_MWAIT;
        end
      end
      S_MWAIT:  if (st.div_done) state_nxt = S_MSET;
      S_MSET: begin
        cmd.op    = OP_MSET;
        state_nxt = S_MN1;
      end
      S_MN1: begin
        cmd.op    = OP_MN1;
        state_nxt = S_MN2;
      end
      S_MN2: begin
        cmd.op    = OP_MN2;
        state_nxt = S_MINDIV;
      end
      S_MINDIV: begin
        cmd.op     = OP_DIV_MIN;
        cmd.div_go = 1'b1;
        state_nxt  = S_MINWAIT;
      end
      S_MINWAIT: if (st.div_done) state_nxt = S_MINSET;
      S_MINSET: begin
        cmd.op    = OP_MIN_SET;
        state_nxt = S_UNMDIV;
      end
      S_UNMDIV: begin
        if (st.use_zero) begin
          cmd.op    = OP_UNM_SET;
          state_nxt = S_WSEL;
        end else begin
          cmd.op     = OP_DIV_UNM;
          cmd.div_go = 1'b1;
          state_nxt  = S_UNMWAIT;
        end
      end
      S_UNMWAIT: if (st.div_done) state_nxt = S_UNMSET;
      S_UNMSET: begin
        cmd.op    = OP_UNM_SET;
        state_nxt = S_WSEL;
      end
      S_WSEL: begin
        if (st.ready_bit && !st.avg_zero) begin
          cmd.op    = OP_WMUL;
          state_nxt = S_WDIV;
        end else begin
          cmd.op    = OP_W_STEP;
          if (st.idx_last) state_nxt = S_RNG;
        end
      end
      S_WDIV: begin
        cmd.op     = OP_DIV_W;
        cmd.div_go = 1'b1;
        state_nxt  = S_WWAIT;
      end
      S_WWAIT:  if (st.div_done) state_nxt = S_WADD;
      S_WADD: begin
        cmd.op    = OP_WADD;
        state_nxt = st.idx_last ? S_RNG : S_WSEL;
      end
      S_RNG: begin
        if (st.range_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_PM_LO;
          state_nxt = S_PMH;
        end
      end
      S_PMH: begin
        cmd.op    = OP_PM_HI;
        state_nxt = S_PADD;
      end
      S_PADD: begin
        cmd.op    = OP_PADD;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.op = OP_PICK_STEP;
        if (st.pick_hit || st.idx_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTH
  a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go |=> (state_r == S_MWAIT) ||
                   (state_r == S_MINWAIT) || (state_r == S_UNMWAIT) ||
                   (state_r == S_WWAIT))
    else $error("divider started without a wait state");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (state_r == S_IDLE))
    else $error("request loaded while busy");
`endif

endmodule

FILE: design/ltwps_dp.sv
// ----------------------------------------------------------------------------
// ltwps_dp
// Datapath: peer averages, mean, weights, range, pick and output register.
// ----------------------------------------------------------------------------
module ltwps_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ltwps_pkg::cmd_t               cmd,
  output ltwps_pkg::stat_t              st,
  input  logic                          in_req_type,
  input  logic [15:0]                   in_ready_mask,
  input  logic [30:0]                   in_random_value,
  input  logic [3:0]                    in_peer_index,
  input  logic [23:0]                   in_time_ms,
  input  logic                          in_valid_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_chosen_peer,
  output logic                          out_found,
  output logic [31:0]                   out_updated_average,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [6:0]                    cfg_wdata
);
  import ltwps_pkg::*;

  logic [6:0]          f_r;
  logic [CNT_W-1:0]    n_r;
  logic [AVG_W-1:0]    avg_r [MAX_PEERS];
  logic [AVG_W-1:0]    mean_r;
  logic [AVG_W-1:0]    use_r;

  logic                rpt_r;
  logic [15:0]         ready_r;
  logic [RND_W-1:0]    rnd_r;
  logic [IDX_W-1:0]    pidx_r;
  logic [TIME_BITS-1:0] time_r;
  logic                vs_r;

  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [NUM_W-1:0]    numer_r;
  logic [1:0]          rq_cnt_r;
  logic [PROD_W-1:0]   rq_acc_r;
  logic [MN_W-1:0]     mn_r;
  logic [DIV_DW-1:0]   den100_r;
  logic [MN_W-1:0]     wden_r;
  logic [W_W-1:0]      minp_r;
  logic [W_W-1:0]      unm_r;
  logic [W_W-1:0]      w_arr [MAX_PEERS];
  logic [RANGE_W-1:0]  range_r;
  logic [62:0]         plo_r;
  logic [59:0]         phi_r;
  logic [RANGE_W-1:0]  r_r;

  logic [IDX_W-1:0]    res_peer_r;
  logic                res_found_r;
  logic [AVG_W-1:0]    res_avg_r;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_peer_r;
  logic                out_found_r;
  logic [AVG_W-1:0]    out_avg_r;

  logic [6:0]          f_eff;
  logic [CNT_W-1:0]    n_eff;
  logic [IDX_W-1:0]    rd_idx;
  logic [AVG_W-1:0]    avg_rd;
  logic [AVG_W-1:0]    ts;
  logic [AVG_W-1:0]    m1;
  logic                idx_in;
  logic                ready_bit;
  logic                idx_last;
  logic [W_W-1:0]      w_cur;
  logic [W_W-1:0]      w_q;
  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic                div_busy;
  logic                div_done;
  logic [DIV_NW-1:0]   div_quo;
  logic [AVG_W-1:0]    rpt_q;
  logic [RQ_H-1:0]     rq_a;
  logic [RQ_H-1:0]     rq_b;
  logic [2*RQ_H-1:0]   rq_p;
  logic [PROD_W-1:0]   rq_term;

  assign f_eff  = (f_r > F_MAX) ? F_MAX : f_r;
  assign n_eff  = (n_r == '0) ? CNT_W'(1) :
                  (n_r > CNT_W'(MAX_PEERS)) ? CNT_W'(MAX_PEERS) : n_r;
  assign rd_idx = rpt_r ? pidx_r : idx_r;
  assign avg_rd = avg_r[rd_idx];
  assign ts     = {time_r, 8'd0};
  assign m1     = (use_r == '0) ? ONE_MS : use_r;
  assign idx_in    = {1'b0, idx_r} < n_eff;
  assign ready_bit = ready_r[idx_r] && idx_in;
  assign idx_last  = {1'b0, idx_r} == (n_eff - CNT_W'(1));
  assign w_cur     = w_arr[idx_r];
  assign w_q       = W_W'(div_quo);
  assign rpt_q     = rq_acc_r[RQ_SHIFT +: AVG_W];

  // Division by 100 as a reciprocal product: one partial product per step.
  assign rq_a = rq_cnt_r[1] ? numer_r[NUM_W-1:RQ_H] : numer_r[RQ_H-1:0];
  assign rq_b = rq_cnt_r[0] ? RECIP_100[NUM_W-1:RQ_H] : RECIP_100[RQ_H-1:0];
  assign rq_p = rq_a * rq_b;

  always_comb begin
    case (rq_cnt_r)
      2'd0:    rq_term = PROD_W'(rq_p);
      2'd3:    rq_term = {rq_p, {(2*RQ_H){1'b0}}};
      default: rq_term = {{RQ_H{1'b0}}, rq_p, {RQ_H{1'b0}}};
    endcase
  end

  // Divider operands follow the operation that starts it.
  always_comb begin
    div_start = cmd.div_go;
    div_num   = WEIGHT_ONE;
    div_den   = DIV_DW'(PERCENT);
    case (cmd.op)
      OP_DIV_MEAN: begin
        div_num = DIV_NW'(sum_r);
        div_den = DIV_DW'(cnt_r);
      end
      OP_DIV_MIN: div_den = den100_r;
      OP_DIV_UNM: div_den = DIV_DW'(mn_r);
      OP_DIV_W:   div_den = DIV_DW'(wden_r);
      default: ;
    endcase
  end

  ltwps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r         <= 7'd90;
      n_r         <= CNT_W'(1);
      mean_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PEERS; i++) avg_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SMOOTHING: f_r <= cfg_wdata;
          CFG_NUM_PEERS: n_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_RPT_FAST: begin
          if (vs_r) avg_r[pidx_r] <= (ts == '0) ? ONE_MS : ts;
        end
        OP_RWB: avg_r[pidx_r] <= (rpt_q == '0) ? ONE_MS : rpt_q;
        OP_MSET: mean_r <= div_quo[AVG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rpt_r       <= in_req_type;
        ready_r     <= in_ready_mask;
        rnd_r       <= in_random_value;
        pidx_r      <= in_peer_index;
        time_r      <= in_time_ms;
        vs_r        <= in_valid_sample;
        idx_r       <= '0;
        sum_r       <= '0;
        cnt_r       <= '0;
        range_r     <= '0;
        use_r       <= mean_r;
        res_peer_r  <= '0;
        res_found_r <= 1'b0;
        res_avg_r   <= '0;
      end
      OP_RPT_FAST: begin
        if (vs_r) res_avg_r <= (ts == '0) ? ONE_MS : ts;
        else      res_avg_r <= avg_rd;
      end
      OP_RMUL: begin
        numer_r  <= NUM_W'(avg_rd) * NUM_W'(f_eff) +
                    NUM_W'(ts) * NUM_W'(PERCENT - f_eff);
        rq_cnt_r <= '0;
        rq_acc_r <= '0;
      end
      OP_RQ_STEP: begin
        rq_acc_r <= rq_acc_r + rq_term;
        rq_cnt_r <= rq_cnt_r + 2'd1;
      end
      OP_RWB:  res_avg_r <= (rpt_q == '0) ? ONE_MS : rpt_q;
      OP_SUM_STEP: begin
        if (ready_bit && avg_rd != '0) begin
          sum_r <= sum_r + SUM_W'(avg_rd);
          cnt_r <= cnt_r + CNT_W'(1);
        end
        idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
      end
      OP_MSET: begin
        if (use_r == '0) use_r <= div_quo[AVG_W-1:0];
      end
      OP_MN1:     mn_r <= MN_W'(m1) * MN_W'(n_eff);
      OP_MN2:     den100_r <= DIV_DW'(mn_r) * DIV_DW'(PERCENT);
      OP_MIN_SET: minp_r <= w_q;
      OP_UNM_SET: unm_r <= (use_r == '0) ? UNMEASURED_WEIGHT : w_q;
      OP_W_STEP: begin
        if (ready_bit) begin
          w_arr[idx_r] <= (unm_r > minp_r) ? unm_r : minp_r;
          range_r      <= range_r + RANGE_W'((unm_r > minp_r) ? unm_r : minp_r);
        end
        idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
      end
      OP_WMUL: wden_r <= MN_W'(avg_rd) * MN_W'(n_eff);
      OP_WADD: begin
        w_arr[idx_r] <= (w_q > minp_r) ? w_q : minp_r;
        range_r      <= range_r + RANGE_W'((w_q > minp_r) ? w_q : minp_r);
        idx_r        <= idx_last ? '0 : idx_r + IDX_W'(1);
      end
      OP_PM_LO: plo_r <= 63'(rnd_r) * 63'(range_r[31:0]);
      OP_PM_HI: phi_r <= 60'(rnd_r) * 60'(range_r[RANGE_W-1:32]);
      OP_PADD:  r_r <= {phi_r, 1'b0} + RANGE_W'(plo_r[62:31]);
      OP_PICK_STEP: begin
        if (ready_bit) begin
          if (r_r < RANGE_W'(w_cur)) begin
            res_peer_r  <= idx_r;
            res_found_r <= 1'b1;
          end else begin
            r_r <= r_r - RANGE_W'(w_cur);
          end
        end
        idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
      end
      OP_OUT: begin
        out_peer_r  <= res_peer_r;
        out_found_r <= res_found_r;
        out_avg_r   <= res_avg_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.is_rpt     = rpt_r;
    st.smp_valid  = vs_r;
    st.avg_zero   = (avg_rd == '0);
    st.idx_last   = idx_last;
    st.ready_bit  = ready_bit;
    st.cnt_zero   = (cnt_r == '0);
    st.use_zero   = (use_r == '0);
    st.div_done   = div_done;
    st.range_zero = (range_r == '0);
    st.pick_hit   = ready_bit && (r_r < RANGE_W'(w_cur));
    st.out_free   = !out_valid_r || !out_stall;
    st.rq_last    = (rq_cnt_r == 2'd3);
  end

  assign out_valid           = out_valid_r;
  assign out_chosen_peer     = out_peer_r;
  assign out_found           = out_found_r;
  assign out_updated_average = out_avg_r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_report_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RWB) |=> (avg_r[pidx_r] != '0))
    else $error("reported average left at zero");
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> ({1'b0, out_peer_r} < n_eff))
    else $error("chosen peer beyond peer count");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Least-time weighted peer selector testbench
// Sends report and select requests through the valid/stall handshake with
// random gaps on both sides. Each request is predicted with a local model of
// the per-peer averages and the running mean, and every result is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ltwps_pkg::*;

  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic [3:0]  peer;
    logic        found;
    logic [31:0] avg;
  } pick_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [15:0] in_ready_mask;
  logic [30:0] in_random_value;
  logic [3:0]  in_peer_index;
  logic [23:0] in_time_ms;
  logic        in_valid_sample;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_chosen_peer;
  logic        out_found;
  logic [31:0] out_updated_average;
  logic        cfg_we;
  logic        cfg_addr;
  logic [6:0]  cfg_wdata;

  logic [31:0] avg_mdl[MAX_PEERS];
  logic [31:0] mean_mdl;
  logic [6:0]  factor_mdl;
  logic [4:0]  peers_mdl;
  pick_t       pick_q[$];
  int          errors;
  bit          sink_stall_en;

  least_time_weighted_peer_select u_top (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    errors++;
  endtask

  function automatic logic [63:0] weight_of(input int i, input logic [63:0] n,
                                            input logic [63:0] mean);
    logic [63:0] d, w, minp;
    d = avg_mdl[i];
    minp = (64'd1 << 48) / ((mean != 0 ? mean : 64'd256) * n * 64'd100);
    if (d == 0) w = (mean == 0) ? (64'd1 << 56) : (64'd1 << 48) / (mean * n);
    else w = (64'd1 << 48) / (d * n);
    return (w > minp) ? w : minp;
  endfunction

  function automatic pick_t predict_pick(input logic rt, input logic [15:0] rdy,
                                         input logic [30:0] rv, input logic [3:0] idx,
                                         input logic [23:0] t, input logic vs);
    pick_t p;
    logic [63:0] f, a, n, sum, cnt, use_m, range, r, w, rnd;
    p = '0;
    if (rt == REQ_REPORT) begin
      f = (factor_mdl > 99) ? 64'd99 : 64'(factor_mdl);
      a = avg_mdl[idx];
      if (vs) begin
        if (a > 0) a = (a * f + 64'(t) * 256 * (100 - f)) / 100;
        else a = 64'(t) * 256;
        if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
        if (a == 0) a = 256;
        avg_mdl[idx] = a[31:0];
      end
      p.avg = a[31:0];
      return p;
    end
    n = (peers_mdl < 1) ? 1 : (peers_mdl > 16) ? 16 : 64'(peers_mdl);
    sum = 0; cnt = 0; use_m = mean_mdl; range = 0;
    for (int i = 0; i < n; i++)
      if (rdy[i] && avg_mdl[i] > 0) begin
        sum += avg_mdl[i];
        cnt++;
      end
    if (cnt > 0) begin
      if (mean_mdl == 0) use_m = sum / cnt;
      mean_mdl = 32'(sum / cnt);
    end
    for (int i = 0; i < n; i++) if (rdy[i]) range += weight_of(i, n, use_m);
    if (range == 0) return p;
    rnd = 64'(rv);
    r = ((rnd * (range >> 32)) << 1) + ((rnd * (range & 64'hFFFF_FFFF)) >> 31);
    for (int i = 0; i < n; i++) begin
      if (!rdy[i]) continue;
      w = weight_of(i, n, use_m);
      if (r < w) begin
        p.peer = i[3:0];
        p.found = 1'b1;
        return p;
      end
      r -= w;
    end
    return p;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Leaves in_valid high after acceptance; at the same falling edge the next
  // call drops it or drives its own request, or the caller drops it.
  task automatic send_request(input logic rt, input logic [15:0] rdy,
                              input logic [30:0] rv, input logic [3:0] idx,
                              input logic [23:0] t, input logic vs);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_ready_mask <= rdy;
    in_random_value <= rv;
    in_peer_index <= idx;
    in_time_ms <= t;
    in_valid_sample <= vs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pick_q.push_back(predict_pick(rt, rdy, rv, idx, t, vs));
    @(negedge clk);
  endtask

  // Waits until every result is in, then writes one register.
  task automatic write_cfg(input logic addr, input logic [6:0] val);
    in_valid <= 1'b0;
    while (pick_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_SMOOTHING) factor_mdl = val;
    else peers_mdl = val[4:0];
  endtask

  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pick_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = pick_q.pop_front();
        if (out_chosen_peer !== e.peer) report_mismatch("chosen_peer", out_chosen_peer, e.peer);
        if (out_found !== e.found) report_mismatch("found", out_found, e.found);
        if (out_updated_average !== e.avg)
          report_mismatch("updated_average", out_updated_average, e.avg);
      end
    end
  end

  always @(negedge clk)
    out_stall <= sink_stall_en ? ($urandom_range(0, 99) < 30) : 1'b0;

  task automatic test_report_extremes();
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd0, 24'd0, 1'b1);
    send_request(REQ_REPORT, 16'hFFFF, 31'h7FFF_FFFF, 4'd0, 24'hFF_FFFF, 1'b1);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd0, 24'd0, 1'b1);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd15, 24'hFF_FFFF, 1'b1);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd15, 24'd5, 1'b0);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd3, 24'd7, 1'b0);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd15, 24'hFF_FFFF, 1'b1);
  endtask

  task automatic test_select_directed();
    send_request(REQ_SELECT, 16'h0, 31'h1234, 4'd0, 24'd0, 1'b0);
    send_request(REQ_SELECT, 16'hFFFF, 31'h0, 4'd0, 24'd0, 1'b0);
    send_request(REQ_SELECT, 16'hFFFF, 31'h7FFF_FFFF, 4'd0, 24'd0, 1'b0);
    write_cfg(CFG_NUM_PEERS, 7'd16);
    send_request(REQ_SELECT, 16'hFFFF, 31'h7FFF_FFFF, 4'd0, 24'd0, 1'b0);
    send_request(REQ_SELECT, 16'h8001, 31'h4000_0000, 4'd0, 24'd0, 1'b0);
    send_request(REQ_SELECT, 16'h0002, 31'h0, 4'd0, 24'd0, 1'b0);
    // Peer count zero behaves as one; above sixteen as sixteen.
    write_cfg(CFG_NUM_PEERS, 7'd0);
    send_request(REQ_SELECT, 16'hFFFE, 31'h55, 4'd0, 24'd0, 1'b0);
    send_request(REQ_SELECT, 16'hFFFF, 31'h55, 4'd0, 24'd0, 1'b0);
    write_cfg(CFG_NUM_PEERS, 7'd31);
    send_request(REQ_SELECT, 16'hFFFF, 31'h3FFF_FFFF, 4'd0, 24'd0, 1'b0);
    // Factor above 99 clamps; 0 takes the sample alone.
    write_cfg(CFG_SMOOTHING, 7'd127);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd15, 24'd1, 1'b1);
    write_cfg(CFG_SMOOTHING, 7'd0);
    send_request(REQ_REPORT, 16'h0, 31'h0, 4'd15, 24'd0, 1'b1);
  endtask

  task automatic test_random(input int count);
    int peers_sel;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) begin
        peers_sel = $urandom_range(0, 9);
        write_cfg(CFG_NUM_PEERS, peers_sel < 3 ? 7'($urandom_range(0, 31))
                                               : 7'($urandom_range(1, 16)));
        write_cfg(CFG_SMOOTHING, 7'($urandom_range(0, 127)));
        sink_stall_en = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 1))
        send_request(REQ_REPORT, 16'($urandom), 31'($urandom), 4'($urandom),
                     $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 2000)),
                     $urandom_range(0, 7) != 0);
      else
        send_request(REQ_SELECT, $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom),
                     31'($urandom), 4'($urandom), 24'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    sink_stall_en = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_ready_mask = '0;
    in_random_value = '0;
    in_peer_index = '0;
    in_time_ms = '0;
    in_valid_sample = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_wdata = '0;
    foreach (avg_mdl[i]) avg_mdl[i] = '0;
    mean_mdl = '0;
    factor_mdl = 7'd90;
    peers_mdl = 5'd1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_report_extremes();
    sink_stall_en = 1'b1;
    test_select_directed();
    test_random(350);
    in_valid <= 1'b0;
    while (pick_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
